// ===== rtl/core/rtos_task_state_scheduler_macros.svh =====
// Assertion macros for the task scheduler; they use clk and arst_n of the module.
`ifndef RTOS_TASK_STATE_SCHEDULER_MACROS_SVH
`define RTOS_TASK_STATE_SCHEDULER_MACROS_SVH

// condition must hold at every edge out of reset
`define RTSCH_AST(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// condition post must hold in the cycle after pre
`define RTSCH_AST_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== rtl/core/rtsch_pkg.sv =====
// Types, constants and bitmap helpers of the task scheduler.
`default_nettype none
package rtsch_pkg;
	localparam int TASK_COUNT = 32;
	localparam int TASK_W = 5;
	localparam int CMP_W = TASK_W + 1;
	localparam int MAP_W = 32;
	localparam int CNT_W = 32;

	typedef enum logic [3:0] {
		OP_CREATE  = 4'd0,
		OP_START   = 4'd1,
		OP_SUSPEND = 4'd2,
		OP_RESUME  = 4'd3,
		OP_DELAY   = 4'd4,
		OP_BLOCK   = 4'd5,
		OP_WAKE    = 4'd6,
		OP_TICK    = 4'd7,
		OP_LOCK    = 4'd8,
		OP_UNLOCK  = 4'd9
	} op_t;

	typedef enum logic [1:0] {
		STAT_DONE    = 2'd0,
		STAT_RANGE   = 2'd1,
		STAT_IGNORED = 2'd2
	} stat_t;

	typedef struct packed {
		logic             shift;
		logic [CNT_W-1:0] wr_val;
	} cell_ctl_t;

	typedef struct packed {
		logic [MAP_W-1:0] ready;
		logic [MAP_W-1:0] run;
		logic             sw;
	} sched_t;

	// highest set bit among 1..31, 0 when none
	function automatic logic [TASK_W-1:0] top_of(input logic [MAP_W-1:0] m);
		logic [TASK_W-1:0] r;
		r = '0;
		for (int i = 1; i < MAP_W; i++) begin
			if (m[i]) r = TASK_W'(i);
		end
		return r;
	endfunction

	function automatic logic [TASK_W-1:0] low_of(input logic [MAP_W-1:0] m);
		logic [TASK_W-1:0] r;
		r = '0;
		for (int i = MAP_W - 1; i >= 0; i--) begin
			if (m[i]) r = TASK_W'(i);
		end
		return r;
	endfunction

	// preemption: unless locked, highest ready task replaces a lower running one or starts when none runs
	function automatic sched_t schedule(input logic [MAP_W-1:0] ready,
			input logic [MAP_W-1:0] run, input logic locked);
		sched_t s;
		logic [TASK_W-1:0] h;
		logic [TASK_W-1:0] r;
		s.ready = ready;
		s.run = run;
		s.sw = 1'b0;
		h = top_of(ready);
		r = top_of(run);
		if (!locked && ready != '0 && (run == '0 || r < h)) begin
			if (run != '0) begin
				s.run = s.run & ~(MAP_W'(1) << r);
				s.ready = s.ready | (MAP_W'(1) << r);
			end
			s.ready = s.ready & ~(MAP_W'(1) << h);
			s.run = s.run | (MAP_W'(1) << h);
			s.sw = 1'b1;
		end
		return s;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/rtsch_if.sv =====
// Request and result channel interfaces of the task scheduler.
`default_nettype none
interface rtsch_in_if;
	logic                        valid;
	logic                        ready;
	logic [3:0]                  opcode;
	logic [rtsch_pkg::TASK_W-1:0] task_req;
	logic [31:0]                 ticks;
	modport source (output valid, opcode, task_req, ticks, input ready);
	modport sink (input valid, opcode, task_req, ticks, output ready);
endinterface

interface rtsch_out_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  status;
	logic                        switched;
	logic [rtsch_pkg::TASK_W-1:0] running_task;
	logic                        none_running;
	logic                        timeout_valid;
	logic [rtsch_pkg::TASK_W-1:0] timeout_task;
	logic                        last;
	logic [31:0]                 tick_count;
	modport source (output valid, status, switched, running_task, none_running,
		timeout_valid, timeout_task, last, tick_count, input ready);
	modport sink (input valid, status, switched, running_task, none_running,
		timeout_valid, timeout_task, last, tick_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rtsch_cell.sv =====
// One task's delay and block counters; shifts toward the chain head.
`default_nettype none
module rtsch_cell (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire rtsch_pkg::cell_ctl_t        ctl,
	input  wire logic                        ld_dly,
	input  wire logic                        ld_blk,
	input  wire logic [rtsch_pkg::CNT_W-1:0] nxt_dly,
	input  wire logic [rtsch_pkg::CNT_W-1:0] nxt_blk,
	output logic      [rtsch_pkg::CNT_W-1:0] dly,
	output logic      [rtsch_pkg::CNT_W-1:0] blk
);
	logic [rtsch_pkg::CNT_W-1:0] dly_q;
	logic [rtsch_pkg::CNT_W-1:0] blk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dly_q <= '0;
			blk_q <= '0;
		end else if (ctl.shift) begin
			dly_q <= nxt_dly;
			blk_q <= nxt_blk;
		end else begin
			if (ld_dly) dly_q <= ctl.wr_val;
			if (ld_blk) blk_q <= ctl.wr_val;
		end
	end

	assign dly = dly_q;
	assign blk = blk_q;
endmodule
`default_nettype wire

// ===== rtl/core/rtsch_chain.sv =====
// Ring of counter cells; cell 0 is the head, the tail takes the updated head.
`default_nettype none
module rtsch_chain (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire rtsch_pkg::cell_ctl_t                 ctl,
	input  wire logic [rtsch_pkg::TASK_COUNT-1:0]     ld_dly,
	input  wire logic [rtsch_pkg::TASK_COUNT-1:0]     ld_blk,
	input  wire logic [rtsch_pkg::CNT_W-1:0]          tail_dly,
	input  wire logic [rtsch_pkg::CNT_W-1:0]          tail_blk,
	output logic      [rtsch_pkg::CNT_W-1:0]          head_dly,
	output logic      [rtsch_pkg::CNT_W-1:0]          head_blk
);
	logic [rtsch_pkg::CNT_W-1:0] dly_w [rtsch_pkg::TASK_COUNT];
	logic [rtsch_pkg::CNT_W-1:0] blk_w [rtsch_pkg::TASK_COUNT];

	for (genvar k = 0; k < rtsch_pkg::TASK_COUNT; k++) begin : g_cell
		logic [rtsch_pkg::CNT_W-1:0] nd;
		logic [rtsch_pkg::CNT_W-1:0] nb;
		if (k == rtsch_pkg::TASK_COUNT - 1) begin : g_tail
			assign nd = tail_dly;
			assign nb = tail_blk;
		end else begin : g_mid
			assign nd = dly_w[k+1];
			assign nb = blk_w[k+1];
		end
		rtsch_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.ld_dly  (ld_dly[k]),
			.ld_blk  (ld_blk[k]),
			.nxt_dly (nd),
			.nxt_blk (nb),
			.dly     (dly_w[k]),
			.blk     (blk_w[k])
		);
	end

	assign head_dly = dly_w[0];
	assign head_blk = blk_w[0];
endmodule
`default_nettype wire

// ===== rtl/core/rtos_task_state_scheduler.sv =====
// Top level of the bitmap priority task scheduler.
// Non-tick requests give their single result in the cycle after acceptance.
// Tick: a walk through the counter ring, a schedule step, then one timeout
// result per expired block counter, then a final result; requests wait meanwhile.
// Throughput: one request per cycle for non-tick opcodes while results are taken.
// Reset clears all bitmaps, counters, lock depth and tick count at once.
`default_nettype none
`include "rtos_task_state_scheduler_macros.svh"
module rtos_task_state_scheduler (
	input wire logic clk,
	input wire logic arst_n,
	rtsch_in_if.sink     req,
	rtsch_out_if.source  rsp
);
	localparam int MW = rtsch_pkg::MAP_W;
	localparam int TW = rtsch_pkg::TASK_W;
	localparam int CW = rtsch_pkg::CNT_W;
	localparam int TC = rtsch_pkg::TASK_COUNT;
	localparam logic [TW-1:0] CNT_LAST = TW'(TC - 1);

	typedef logic [rtsch_pkg::CMP_W-1:0] cmp_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_WALK  = 4'b0010,
		ST_SCHED = 4'b0100,
		ST_EMIT  = 4'b1000
	} fsm_t;

	fsm_t st_q, st_n;
	logic [MW-1:0] ready_q, run_q, dly_q, sus_q, blk_q, dsus_q, bsus_q, tof_q, exp_q;
	logic [MW-1:0] ready_n, run_n, dly_n, sus_n, blk_n, dsus_n, bsus_n, tof_n, exp_n;
	logic [CW-1:0] lock_q, lock_n, sys_q, sys_n;
	logic          pend_q, pend_n, sw_q, sw_n;
	logic [TW-1:0] cnt_q, cnt_n;

	logic          ov_q;
	logic [1:0]    o_status_q;
	logic          o_sw_q, o_none_q, o_tv_q, o_last_q;
	logic [TW-1:0] o_run_q, o_tt_q;
	logic [31:0]   o_tick_q;

	logic          o_load;
	logic [1:0]    o_status_n;
	logic          o_sw_n, o_tv_n, o_last_n;
	logic [TW-1:0] o_tt_n;

	rtsch_pkg::cell_ctl_t ctl;
	logic [TC-1:0] ld_dly, ld_blk;
	logic [CW-1:0] head_dly, head_blk, tail_dly, tail_blk;

	logic out_free, acc;

	assign out_free = !ov_q || rsp.ready;
	assign req.ready = (st_q == ST_IDLE) && out_free;
	assign acc = req.valid && req.ready;

	rtsch_chain u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.ld_dly   (ld_dly),
		.ld_blk   (ld_blk),
		.tail_dly (tail_dly),
		.tail_blk (tail_blk),
		.head_dly (head_dly),
		.head_blk (head_blk)
	);

	always_comb begin
		logic [TW-1:0] t;
		logic [MW-1:0] b, m, all;
		logic [TW-1:0] r;
		logic          idx_op;
		rtsch_pkg::sched_t sc;
		logic [CW-1:0] nd, nb;

		st_n = st_q;
		ready_n = ready_q; run_n = run_q; dly_n = dly_q; sus_n = sus_q;
		blk_n = blk_q; dsus_n = dsus_q; bsus_n = bsus_q; tof_n = tof_q; exp_n = exp_q;
		lock_n = lock_q; sys_n = sys_q; pend_n = pend_q; sw_n = sw_q; cnt_n = cnt_q;
		o_load = 1'b0;
		o_status_n = rtsch_pkg::STAT_DONE;
		o_sw_n = 1'b0; o_tv_n = 1'b0; o_last_n = 1'b1; o_tt_n = '0;
		ctl.shift = 1'b0;
		ctl.wr_val = '0;
		ld_dly = '0; ld_blk = '0;
		t = req.task_req;
		b = MW'(1) << t;
		all = ready_q | run_q | dly_q | sus_q | blk_q | dsus_q | bsus_q;
		r = rtsch_pkg::top_of(run_q);
		m = MW'(1) << cnt_q;
		sc = '0;
		nd = head_dly;
		nb = head_blk;
		idx_op = (req.opcode == rtsch_pkg::OP_CREATE) || (req.opcode == rtsch_pkg::OP_SUSPEND)
			|| (req.opcode == rtsch_pkg::OP_RESUME) || (req.opcode == rtsch_pkg::OP_WAKE);
		if ((req.opcode == rtsch_pkg::OP_DELAY) || (req.opcode == rtsch_pkg::OP_BLOCK))
			ctl.wr_val = req.ticks;

		case (st_q)
			ST_IDLE: begin
				if (acc) begin
					o_load = 1'b1;
					if (idx_op && (cmp_t'(t) >= cmp_t'(TC))) begin
						o_status_n = rtsch_pkg::STAT_RANGE;
					end else begin
						case (req.opcode)
							rtsch_pkg::OP_CREATE: begin
								if ((all & b) != '0) o_status_n = rtsch_pkg::STAT_IGNORED;
								else begin
									ld_dly[t] = 1'b1;
									ld_blk[t] = 1'b1;
									tof_n = tof_q & ~b;
									ready_n = ready_q | b;
								end
							end
							rtsch_pkg::OP_START: begin
								if (run_q != '0 || ready_q == '0) begin
									o_status_n = rtsch_pkg::STAT_IGNORED;
								end else begin
									ready_n = ready_q & ~(MW'(1) << rtsch_pkg::top_of(ready_q));
									run_n = MW'(1) << rtsch_pkg::top_of(ready_q);
									o_sw_n = 1'b1;
								end
							end
							rtsch_pkg::OP_SUSPEND: begin
								if (((sus_q | dsus_q | bsus_q) & b) != '0) begin
									o_status_n = rtsch_pkg::STAT_IGNORED;
								end else if ((ready_q & b) != '0) begin
									ready_n = ready_q & ~b; sus_n = sus_q | b;
								end else if ((run_q & b) != '0) begin
									sus_n = sus_q | b;
									sc = rtsch_pkg::schedule(ready_q, run_q & ~b, lock_q != '0);
									ready_n = sc.ready; run_n = sc.run; o_sw_n = sc.sw;
								end else if ((dly_q & b) != '0) begin
									dly_n = dly_q & ~b; dsus_n = dsus_q | b;
								end else if ((blk_q & b) != '0) begin
									blk_n = blk_q & ~b; bsus_n = bsus_q | b;
								end else begin
									o_status_n = rtsch_pkg::STAT_IGNORED;
								end
							end
							rtsch_pkg::OP_RESUME: begin
								if ((sus_q & b) != '0) begin
									sus_n = sus_q & ~b;
									sc = rtsch_pkg::schedule(ready_q | b, run_q, lock_q != '0);
									ready_n = sc.ready; run_n = sc.run; o_sw_n = sc.sw;
								end else if ((dsus_q & b) != '0) begin
									dsus_n = dsus_q & ~b; dly_n = dly_q | b;
								end else if ((bsus_q & b) != '0) begin
									bsus_n = bsus_q & ~b; blk_n = blk_q | b;
								end else begin
									o_status_n = rtsch_pkg::STAT_IGNORED;
								end
							end
							rtsch_pkg::OP_DELAY, rtsch_pkg::OP_BLOCK: begin
								if (run_q == '0) begin
									o_status_n = rtsch_pkg::STAT_IGNORED;
								end else begin
									if (req.opcode == rtsch_pkg::OP_DELAY) begin
										ld_dly[r] = 1'b1;
										dly_n = dly_q | (MW'(1) << r);
									end else begin
										ld_blk[r] = 1'b1;
										tof_n = tof_q & ~(MW'(1) << r);
										blk_n = blk_q | (MW'(1) << r);
									end
									sc = rtsch_pkg::schedule(ready_q, run_q & ~(MW'(1) << r),
										lock_q != '0);
									ready_n = sc.ready; run_n = sc.run; o_sw_n = sc.sw;
								end
							end
							rtsch_pkg::OP_WAKE: begin
								if ((blk_q & b) != '0) begin
									ld_blk[t] = 1'b1;
									blk_n = blk_q & ~b;
									sc = rtsch_pkg::schedule(ready_q | b, run_q, lock_q != '0);
									ready_n = sc.ready; run_n = sc.run; o_sw_n = sc.sw;
								end else if ((bsus_q & b) != '0) begin
									ld_blk[t] = 1'b1;
									bsus_n = bsus_q & ~b; sus_n = sus_q | b;
								end else begin
									o_status_n = rtsch_pkg::STAT_IGNORED;
								end
							end
							rtsch_pkg::OP_TICK: begin
								o_load = 1'b0;
								sys_n = sys_q + CW'(1);
								exp_n = '0; pend_n = 1'b0; sw_n = 1'b0; cnt_n = '0;
								st_n = ST_WALK;
							end
							rtsch_pkg::OP_LOCK: begin
								if (lock_q != '1) lock_n = lock_q + CW'(1);
							end
							rtsch_pkg::OP_UNLOCK: begin
								if (lock_q != '0) lock_n = lock_q - CW'(1);
								sc = rtsch_pkg::schedule(ready_q, run_q, lock_n != '0);
								ready_n = sc.ready; run_n = sc.run; o_sw_n = sc.sw;
							end
							default: o_status_n = rtsch_pkg::STAT_IGNORED;
						endcase
					end
				end
			end
			ST_WALK: begin
				ctl.shift = 1'b1;
				if (((dly_q | dsus_q) & m) != '0) begin
					if (head_dly != '0) begin
						nd = head_dly - CW'(1);
						if (nd == '0) begin
							if ((dly_q & m) != '0) begin
								dly_n = dly_q & ~m; ready_n = ready_q | m; pend_n = 1'b1;
							end else begin
								dsus_n = dsus_q & ~m; sus_n = sus_q | m;
							end
						end
					end
				end else if (((blk_q | bsus_q) & m) != '0) begin
					if (head_blk != '0) begin
						nb = head_blk - CW'(1);
						if (nb == '0) begin
							tof_n = tof_q | m;
							exp_n = exp_q | m;
							if ((blk_q & m) != '0) begin
								blk_n = blk_q & ~m; ready_n = ready_q | m; pend_n = 1'b1;
							end else begin
								bsus_n = bsus_q & ~m; sus_n = sus_q | m;
							end
						end
					end
				end
				cnt_n = cnt_q + TW'(1);
				if (cnt_q == CNT_LAST) begin
					cnt_n = '0;
					st_n = ST_SCHED;
				end
			end
			ST_SCHED: begin
				// one pass at the end gives the same state as one per expiry
				if (pend_q) begin
					sc = rtsch_pkg::schedule(ready_q, run_q, lock_q != '0);
					ready_n = sc.ready; run_n = sc.run; sw_n = sc.sw;
				end
				st_n = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					o_load = 1'b1;
					if (exp_q != '0) begin
						o_tv_n = 1'b1;
						o_last_n = 1'b0;
						o_tt_n = rtsch_pkg::low_of(exp_q);
						exp_n = exp_q & ~(MW'(1) << rtsch_pkg::low_of(exp_q));
					end else begin
						o_sw_n = sw_q;
						st_n = ST_IDLE;
					end
				end
			end
			default: st_n = ST_IDLE;
		endcase
		tail_dly = nd;
		tail_blk = nb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ready_q <= '0; run_q <= '0; dly_q <= '0; sus_q <= '0;
			blk_q <= '0; dsus_q <= '0; bsus_q <= '0; tof_q <= '0; exp_q <= '0;
			lock_q <= '0; sys_q <= '0; pend_q <= 1'b0; sw_q <= 1'b0; cnt_q <= '0;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_n;
			ready_q <= ready_n; run_q <= run_n; dly_q <= dly_n; sus_q <= sus_n;
			blk_q <= blk_n; dsus_q <= dsus_n; bsus_q <= bsus_n; tof_q <= tof_n;
			exp_q <= exp_n;
			lock_q <= lock_n; sys_q <= sys_n; pend_q <= pend_n; sw_q <= sw_n;
			cnt_q <= cnt_n;
			if (o_load) ov_q <= 1'b1;
			else if (rsp.ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (o_load) begin
			o_status_q <= o_status_n;
			o_sw_q <= o_sw_n;
			o_run_q <= rtsch_pkg::top_of(run_n);
			o_none_q <= (run_n == '0);
			o_tv_q <= o_tv_n;
			o_tt_q <= o_tt_n;
			o_last_q <= o_last_n;
			o_tick_q <= sys_n;
		end
	end

	assign rsp.valid = ov_q;
	assign rsp.status = o_status_q;
	assign rsp.switched = o_sw_q;
	assign rsp.running_task = o_run_q;
	assign rsp.none_running = o_none_q;
	assign rsp.timeout_valid = o_tv_q;
	assign rsp.timeout_task = o_tt_q;
	assign rsp.last = o_last_q;
	assign rsp.tick_count = o_tick_q;

	`RTSCH_AST(a_run_single, $onehot0(run_q), "more than one task running")
	`RTSCH_AST(a_idle_aligned, (st_q != ST_IDLE) || (cnt_q == '0), "counter ring misaligned")
	`RTSCH_AST_NEXT(a_walk_end, (st_q == ST_WALK) && (cnt_q == CNT_LAST), st_q == ST_SCHED,
		"walk did not end after last cell")
	`RTSCH_AST(a_busy_no_req, (st_q == ST_IDLE) || !req.ready, "request taken during tick")
endmodule
`default_nettype wire

// ===== tb/sv/tb_rtos_task_state_scheduler.sv =====
// Self-checking testbench for the bitmap priority task scheduler.
`timescale 1ns / 100ps
`default_nettype none
module tb_rtos_task_state_scheduler;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 250;

	typedef struct packed {
		logic [1:0]  status;
		logic        switched;
		logic [4:0]  running_task;
		logic        none_running;
		logic        timeout_valid;
		logic [4:0]  timeout_task;
		logic        last;
		logic [31:0] tick_count;
	} sched_rsp_t;

	typedef struct {
		rtsch_pkg::op_t op;
		logic [4:0]     tsk;
		logic [31:0]    ticks;
		logic           has_exp;
		logic [1:0]     exp_status;
	} dir_row_t;

	logic clk;
	logic arst_n;

	rtsch_in_if  req ();
	rtsch_out_if rsp ();

	rtos_task_state_scheduler dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	// shadow scheduler state
	logic [31:0] m_ready, m_run, m_delay, m_susp, m_block, m_dsusp, m_bsusp;
	logic [31:0] m_dleft [32];
	logic [31:0] m_bleft [32];
	logic [31:0] m_lock, m_ticks;

	sched_rsp_t  expected_rsp [$];
	logic [1:0]  checked_status [$];
	logic        status_known [$];
	int          mismatches;
	int          idle_cycles;
	bit          hold_rx;
	bit          rx_active;

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [4:0] highest(input logic [31:0] m);
		logic [4:0] r;
		r = '0;
		for (int i = 1; i < 32; i++) if (m[i]) r = 5'(i);
		return r;
	endfunction

	function automatic logic try_preempt();
		logic [4:0] h, r;
		if (m_lock != 0 || m_ready == 0) return 1'b0;
		h = highest(m_ready);
		if (m_run != 0) begin
			r = highest(m_run);
			if (r >= h) return 1'b0;
			m_run[r] = 1'b0;
			m_ready[r] = 1'b1;
		end
		m_ready[h] = 1'b0;
		m_run[h] = 1'b1;
		return 1'b1;
	endfunction

	function automatic sched_rsp_t make_rsp(input logic [1:0] st, input logic sw,
			input logic tv, input logic [4:0] tt, input logic lst);
		sched_rsp_t o;
		o.status = st;
		o.switched = sw;
		o.running_task = highest(m_run);
		o.none_running = (m_run == 0);
		o.timeout_valid = tv;
		o.timeout_task = tt;
		o.last = lst;
		o.tick_count = m_ticks;
		return o;
	endfunction

	task automatic predict_request(input rtsch_pkg::op_t op, input logic [4:0] t,
			input logic [31:0] tk, input logic has_exp, input logic [1:0] exp_st);
		logic [1:0] st;
		logic sw;
		logic [4:0] r;
		logic [31:0] all, expired;
		st = rtsch_pkg::STAT_DONE;
		sw = 1'b0;
		expired = '0;
		all = m_ready | m_run | m_delay | m_susp | m_block | m_dsusp | m_bsusp;
		case (op)
			rtsch_pkg::OP_CREATE: begin
				if (all[t]) st = rtsch_pkg::STAT_IGNORED;
				else begin
					m_dleft[t] = 0;
					m_bleft[t] = 0;
					m_ready[t] = 1'b1;
				end
			end
			rtsch_pkg::OP_START: begin
				if (m_run != 0 || m_ready == 0) st = rtsch_pkg::STAT_IGNORED;
				else begin
					r = highest(m_ready);
					m_ready[r] = 1'b0;
					m_run[r] = 1'b1;
					sw = 1'b1;
				end
			end
			rtsch_pkg::OP_SUSPEND: begin
				if (m_susp[t] | m_dsusp[t] | m_bsusp[t]) st = rtsch_pkg::STAT_IGNORED;
				else if (m_ready[t]) begin
					m_ready[t] = 0; m_susp[t] = 1;
				end else if (m_run[t]) begin
					m_run[t] = 0; m_susp[t] = 1; sw = try_preempt();
				end else if (m_delay[t]) begin
					m_delay[t] = 0; m_dsusp[t] = 1;
				end else if (m_block[t]) begin
					m_block[t] = 0; m_bsusp[t] = 1;
				end else st = rtsch_pkg::STAT_IGNORED;
			end
			rtsch_pkg::OP_RESUME: begin
				if (m_susp[t]) begin
					m_susp[t] = 0; m_ready[t] = 1; sw = try_preempt();
				end else if (m_dsusp[t]) begin
					m_dsusp[t] = 0; m_delay[t] = 1;
				end else if (m_bsusp[t]) begin
					m_bsusp[t] = 0; m_block[t] = 1;
				end else st = rtsch_pkg::STAT_IGNORED;
			end
			rtsch_pkg::OP_DELAY, rtsch_pkg::OP_BLOCK: begin
				if (m_run == 0) st = rtsch_pkg::STAT_IGNORED;
				else begin
					r = highest(m_run);
					m_run[r] = 0;
					if (op == rtsch_pkg::OP_DELAY) begin
						m_dleft[r] = tk; m_delay[r] = 1;
					end else begin
						m_bleft[r] = tk; m_block[r] = 1;
					end
					sw = try_preempt();
				end
			end
			rtsch_pkg::OP_WAKE: begin
				if (m_block[t]) begin
					m_bleft[t] = 0; m_block[t] = 0; m_ready[t] = 1; sw = try_preempt();
				end else if (m_bsusp[t]) begin
					m_bleft[t] = 0; m_bsusp[t] = 0; m_susp[t] = 1;
				end else st = rtsch_pkg::STAT_IGNORED;
			end
			rtsch_pkg::OP_TICK: begin
				m_ticks = m_ticks + 1;
				for (int i = 0; i < 32; i++) begin
					if (m_delay[i] | m_dsusp[i]) begin
						if (m_dleft[i] != 0) begin
							m_dleft[i] = m_dleft[i] - 1;
							if (m_dleft[i] == 0) begin
								if (m_delay[i]) begin
									m_delay[i] = 0; m_ready[i] = 1;
									if (try_preempt()) sw = 1;
								end else begin
									m_dsusp[i] = 0; m_susp[i] = 1;
								end
							end
						end
					end else if (m_block[i] | m_bsusp[i]) begin
						if (m_bleft[i] != 0) begin
							m_bleft[i] = m_bleft[i] - 1;
							if (m_bleft[i] == 0) begin
								expired[i] = 1;
								if (m_block[i]) begin
									m_block[i] = 0; m_ready[i] = 1;
									if (try_preempt()) sw = 1;
								end else begin
									m_bsusp[i] = 0; m_susp[i] = 1;
								end
							end
						end
					end
				end
				for (int i = 0; i < 32; i++) if (expired[i]) begin
					expected_rsp.push_back(make_rsp(rtsch_pkg::STAT_DONE, 0, 1, 5'(i), 0));
					status_known.push_back(1'b0);
					checked_status.push_back('0);
				end
			end
			rtsch_pkg::OP_LOCK: if (m_lock != 32'hFFFF_FFFF) m_lock = m_lock + 1;
			rtsch_pkg::OP_UNLOCK: begin
				if (m_lock > 0) m_lock = m_lock - 1;
				if (m_lock == 0) sw = try_preempt();
			end
			default: st = rtsch_pkg::STAT_IGNORED;
		endcase
		expected_rsp.push_back(make_rsp(st, sw, 0, '0, 1));
		status_known.push_back(has_exp);
		checked_status.push_back(exp_st);
	endtask

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_request(input rtsch_pkg::op_t op, input logic [4:0] t,
			input logic [31:0] tk, input logic has_exp, input logic [1:0] exp_st);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.opcode <= op;
		req.task_req <= t;
		req.ticks <= tk;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		predict_request(op, t, tk, has_exp, exp_st);
		@(negedge clk);
	endtask

	// receiver with random stalls; hold_rx forces a long hold-off
	initial begin
		int stall;
		sched_rsp_t want;
		logic kn;
		logic [1:0] ks;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_rx) begin
				rsp.ready <= 1'b0;
				repeat (300) @(negedge clk);
				hold_rx = 1'b0;
			end
			stall = rx_active ? $urandom_range(0, 14) : 0;
			if ($urandom_range(0, 3) == 0) stall = 0;
			if (stall != 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
			while (!rsp.valid) @(posedge clk);
			if (expected_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", sched_rsp_t'({
					rsp.status, rsp.switched, rsp.running_task, rsp.none_running,
					rsp.timeout_valid, rsp.timeout_task, rsp.last, rsp.tick_count}));
			end else begin
				want = expected_rsp.pop_front();
				kn = status_known.pop_front();
				ks = checked_status.pop_front();
				if (rsp.status !== want.status || rsp.switched !== want.switched
						|| rsp.running_task !== want.running_task
						|| rsp.none_running !== want.none_running
						|| rsp.timeout_valid !== want.timeout_valid
						|| rsp.timeout_task !== want.timeout_task
						|| rsp.last !== want.last || rsp.tick_count !== want.tick_count
						|| (kn && rsp.status !== ks)) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch exp %p got st=%0d sw=%0b run=%0d none=%0b",
							" tv=%0b tt=%0d last=%0b tc=%0d"},
							want, rsp.status, rsp.switched, rsp.running_task,
							rsp.none_running, rsp.timeout_valid, rsp.timeout_task,
							rsp.last, rsp.tick_count);
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	dir_row_t dir_rows [$];

	task automatic add_row(input rtsch_pkg::op_t op, input logic [4:0] t,
			input logic [31:0] tk, input logic he, input logic [1:0] es);
		dir_row_t d;
		d.op = op; d.tsk = t; d.ticks = tk; d.has_exp = he; d.exp_status = es;
		dir_rows.push_back(d);
	endtask

	initial begin
		rtsch_pkg::op_t op;
		logic [4:0] t;
		logic [31:0] tk;
		int pick;
		m_ready = 0; m_run = 0; m_delay = 0; m_susp = 0; m_block = 0;
		m_dsusp = 0; m_bsusp = 0; m_lock = 0; m_ticks = 0;
		for (int i = 0; i < 32; i++) begin
			m_dleft[i] = 0; m_bleft[i] = 0;
		end
		mismatches = 0; idle_cycles = 0; hold_rx = 0; rx_active = 1;
		req.valid = 1'b0; req.opcode = '0; req.task_req = '0; req.ticks = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		add_row(rtsch_pkg::OP_START, 0, 0, 1, rtsch_pkg::STAT_IGNORED);
		add_row(rtsch_pkg::OP_DELAY, 0, 5, 1, rtsch_pkg::STAT_IGNORED);
		add_row(rtsch_pkg::OP_RESUME, 3, 0, 1, rtsch_pkg::STAT_IGNORED);
		add_row(rtsch_pkg::OP_CREATE, 0, 0, 1, rtsch_pkg::STAT_DONE);
		add_row(rtsch_pkg::OP_CREATE, 31, 0, 1, rtsch_pkg::STAT_DONE);
		add_row(rtsch_pkg::OP_CREATE, 31, 0, 1, rtsch_pkg::STAT_IGNORED);
		add_row(rtsch_pkg::OP_CREATE, 5, 0, 1, rtsch_pkg::STAT_DONE);
		add_row(rtsch_pkg::OP_START, 0, 0, 1, rtsch_pkg::STAT_DONE);
		add_row(rtsch_pkg::OP_BLOCK, 0, 2, 0, 0);
		add_row(rtsch_pkg::OP_DELAY, 0, 1, 0, 0);
		add_row(rtsch_pkg::OP_TICK, 0, 0, 0, 0);
		add_row(rtsch_pkg::OP_TICK, 0, 0, 0, 0);
		add_row(rtsch_pkg::OP_LOCK, 0, 0, 1, rtsch_pkg::STAT_DONE);
		add_row(rtsch_pkg::OP_SUSPEND, 31, 0, 0, 0);
		add_row(rtsch_pkg::OP_CREATE, 12, 0, 0, 0);
		add_row(rtsch_pkg::OP_RESUME, 31, 0, 0, 0);
		add_row(rtsch_pkg::OP_UNLOCK, 0, 0, 0, 0);
		add_row(rtsch_pkg::OP_BLOCK, 0, 32'hFFFF_FFFF, 0, 0);
		add_row(rtsch_pkg::OP_SUSPEND, 31, 0, 0, 0);
		add_row(rtsch_pkg::OP_WAKE, 31, 0, 0, 0);
		add_row(rtsch_pkg::OP_DELAY, 0, 0, 0, 0);
		add_row(rtsch_pkg::OP_WAKE, 1, 0, 1, rtsch_pkg::STAT_IGNORED);
		add_row(rtsch_pkg::OP_UNLOCK, 0, 0, 0, 0);
		add_row(rtsch_pkg::op_t'(4'hF), 0, 0, 1, rtsch_pkg::STAT_IGNORED);
		foreach (dir_rows[i])
			send_request(dir_rows[i].op, dir_rows[i].tsk, dir_rows[i].ticks,
				dir_rows[i].has_exp, dir_rows[i].exp_status);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 120) hold_rx = 1'b1;
			rx_active = (n % 80) < 60;
			pick = $urandom_range(0, 99);
			t = $urandom_range(0, 31);
			tk = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 4);
			if (pick < 18) op = rtsch_pkg::OP_CREATE;
			else if (pick < 24) op = rtsch_pkg::OP_START;
			else if (pick < 32) op = rtsch_pkg::OP_SUSPEND;
			else if (pick < 40) op = rtsch_pkg::OP_RESUME;
			else if (pick < 50) op = rtsch_pkg::OP_DELAY;
			else if (pick < 60) op = rtsch_pkg::OP_BLOCK;
			else if (pick < 66) op = rtsch_pkg::OP_WAKE;
			else if (pick < 88) op = rtsch_pkg::OP_TICK;
			else if (pick < 93) op = rtsch_pkg::OP_LOCK;
			else if (pick < 98) op = rtsch_pkg::OP_UNLOCK;
			else op = rtsch_pkg::op_t'($urandom_range(10, 15));
			send_request(op, t, tk, 0, 0);
		end
		req.valid <= 1'b0;
		rx_active = 1'b0;
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire
